// ===== design/anee_pkg.sv =====
// Types, character codes and helper functions shared by the emitter modules.
`default_nettype none

package anee_pkg;

  // Input command item
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [7:0]  color_code;
  } anee_in_t;

  // Output character item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } anee_out_t;

  // Command kinds
  localparam logic [2:0] KIND_DEC = 3'd0;
  localparam logic [2:0] KIND_HEX = 3'd1;
  localparam logic [2:0] KIND_CUR = 3'd2;
  localparam logic [2:0] KIND_COL = 3'd3;
  localparam logic [2:0] KIND_CLR = 3'd4;

  // ASCII characters
  localparam logic [7:0] CH_ESC  = 8'd27;
  localparam logic [7:0] CH_LBRK = 8'h5B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_TWO  = 8'h32;
  localparam logic [7:0] CH_J    = 8'h4A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h41;

  // Byte source selects for the output register
  localparam logic [2:0] SEL_ESC   = 3'd0;
  localparam logic [2:0] SEL_LBRK  = 3'd1;
  localparam logic [2:0] SEL_SEMI  = 3'd2;
  localparam logic [2:0] SEL_H     = 3'd3;
  localparam logic [2:0] SEL_M     = 3'd4;
  localparam logic [2:0] SEL_TWO   = 3'd5;
  localparam logic [2:0] SEL_J     = 3'd6;
  localparam logic [2:0] SEL_DIGIT = 3'd7;

  // Operand selects for the number converter
  localparam logic [1:0] OP_VALUE = 2'd0;
  localparam logic [1:0] OP_ROW   = 2'd1;
  localparam logic [1:0] OP_COL   = 2'd2;
  localparam logic [1:0] OP_COLOR = 2'd3;

  // Digit register geometry: ten 4-bit digits
  localparam int NUM_DIGITS = 10;
  localparam int DIG_W      = 4 * NUM_DIGITS;
  localparam logic [3:0] CONV_STEPS = 4'd8;

  // Controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       load;
    logic [1:0] op_sel;
    logic       hex;
    logic       step;
    logic       fix;
    logic       emit;
    logic [2:0] sel;
    logic       last;
  } anee_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] kind;
    logic       conv_done;
    logic       dig_last;
    logic       out_free;
  } anee_sts_t;

  // Map one digit to its ASCII character, upper-case for hex
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

  // Count significant digits, at least one
  function automatic logic [3:0] sig_digits(input logic [DIG_W-1:0] d);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (d[4*i +: 4] != 4'd0) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== design/anee_dp.sv =====
// Datapath: command register, digit converter, digit register and output register.
`default_nettype none

module anee_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire anee_pkg::anee_in_t in_data,
  input  wire anee_pkg::anee_cmd_t cmd,
  output anee_pkg::anee_sts_t     sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output anee_pkg::anee_out_t     out_data
);

  anee_pkg::anee_in_t          item_r;
  logic [31:0]                 bin_r, bin_nxt;
  logic [anee_pkg::DIG_W-1:0]  bcd_r, bcd_nxt;
  logic [3:0]                  cnt_r;
  logic [anee_pkg::DIG_W-1:0]  digs_r;
  logic [3:0]                  left_r;
  logic                        out_valid_r;
  anee_pkg::anee_out_t         out_r;
  logic [31:0]                 operand;
  logic [3:0]                  idx;
  logic [3:0]                  nib;
  logic [7:0]                  byte_nxt;

  // Select the number to convert
  always_comb begin
    case (cmd.op_sel)
      anee_pkg::OP_VALUE: operand = item_r.value;
      anee_pkg::OP_ROW:   operand = {24'd0, item_r.row};
      anee_pkg::OP_COL:   operand = {24'd0, item_r.column};
      anee_pkg::OP_COLOR: operand = {24'd0, item_r.color_code};
      default:            operand = item_r.value;
    endcase
  end

  // Four double-dabble bit steps per cycle
  always_comb begin
    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    for (int k = 0; k < 4; k++) begin
      for (int d = 0; d < anee_pkg::NUM_DIGITS; d++) begin
        if (bcd_nxt[4*d +: 4] >= 4'd5) begin
          bcd_nxt[4*d +: 4] = bcd_nxt[4*d +: 4] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[anee_pkg::DIG_W-2:0], bin_nxt[31]};
      bin_nxt = {bin_nxt[30:0], 1'b0};
    end
  end

  // Hold the command and run the converter
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.load) begin
      bin_r <= operand;
      if (cmd.hex) begin
        bcd_r <= {8'd0, operand};
      end else begin
        bcd_r <= '0;
      end
    end else if (cmd.step) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
    if (cmd.fix) begin
      digs_r <= bcd_r;
    end
  end

  // Track conversion steps and remaining digits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      left_r <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r <= cmd.hex ? anee_pkg::CONV_STEPS : 4'd0;
      end else if (cmd.step) begin
        cnt_r <= cnt_r + 4'd1;
      end
      if (cmd.fix) begin
        left_r <= anee_pkg::sig_digits(bcd_r);
      end else if (cmd.emit && cmd.sel == anee_pkg::SEL_DIGIT) begin
        left_r <= left_r - 4'd1;
      end
    end
  end

  // Pick the next byte
  assign idx = left_r - 4'd1;
  assign nib = digs_r[{idx, 2'b00} +: 4];

  always_comb begin
    case (cmd.sel)
      anee_pkg::SEL_ESC:   byte_nxt = anee_pkg::CH_ESC;
      anee_pkg::SEL_LBRK:  byte_nxt = anee_pkg::CH_LBRK;
      anee_pkg::SEL_SEMI:  byte_nxt = anee_pkg::CH_SEMI;
      anee_pkg::SEL_H:     byte_nxt = anee_pkg::CH_H;
      anee_pkg::SEL_M:     byte_nxt = anee_pkg::CH_M;
      anee_pkg::SEL_TWO:   byte_nxt = anee_pkg::CH_TWO;
      anee_pkg::SEL_J:     byte_nxt = anee_pkg::CH_J;
      anee_pkg::SEL_DIGIT: byte_nxt = anee_pkg::digit_char(nib);
      default:             byte_nxt = anee_pkg::CH_ESC;
    endcase
  end

  // Output register: load on emit, drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.out_byte <= byte_nxt;
      out_r.last     <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.kind      = item_r.kind;
  assign sts.conv_done = (cnt_r == anee_pkg::CONV_STEPS);
  assign sts.dig_last  = (left_r == 4'd1);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ===== design/anee_ctrl.sv =====
// Controller: sequences the bytes of one command through the datapath.
`default_nettype none

module anee_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire anee_pkg::anee_sts_t sts,
  output anee_pkg::anee_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_ESC  = 4'd2;
  localparam logic [3:0] S_BRK  = 4'd3;
  localparam logic [3:0] S_LOAD = 4'd4;
  localparam logic [3:0] S_CONV = 4'd5;
  localparam logic [3:0] S_DIGS = 4'd6;
  localparam logic [3:0] S_SEMI = 4'd7;
  localparam logic [3:0] S_TAIL = 4'd8;
  localparam logic [3:0] S_TWO  = 4'd9;
  localparam logic [3:0] S_JAY  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       second_r, second_nxt;
  logic       is_num;

  assign is_num   = (sts.kind == anee_pkg::KIND_DEC) || (sts.kind == anee_pkg::KIND_HEX);
  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    cmd        = '0;
    cmd.hex    = (sts.kind == anee_pkg::KIND_HEX);
    case (sts.kind)
      anee_pkg::KIND_CUR: cmd.op_sel = second_r ? anee_pkg::OP_COL : anee_pkg::OP_ROW;
      anee_pkg::KIND_COL: cmd.op_sel = anee_pkg::OP_COLOR;
      default:            cmd.op_sel = anee_pkg::OP_VALUE;
    endcase
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        second_nxt = 1'b0;
        case (sts.kind)
          anee_pkg::KIND_DEC, anee_pkg::KIND_HEX: state_nxt = S_LOAD;
          anee_pkg::KIND_CUR, anee_pkg::KIND_COL, anee_pkg::KIND_CLR: state_nxt = S_ESC;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ESC: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = anee_pkg::SEL_ESC;
          state_nxt = S_BRK;
        end
      end
      S_BRK: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = anee_pkg::SEL_LBRK;
          state_nxt = (sts.kind == anee_pkg::KIND_CLR) ? S_TWO : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_CONV;
      end
      S_CONV: begin
        if (sts.conv_done) begin
          cmd.fix   = 1'b1;
          state_nxt = S_DIGS;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DIGS: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = anee_pkg::SEL_DIGIT;
          cmd.last = sts.dig_last && is_num;
          if (sts.dig_last) begin
            if (is_num) begin
              state_nxt = S_IDLE;
            end else if (sts.kind == anee_pkg::KIND_CUR && !second_r) begin
              state_nxt = S_SEMI;
            end else begin
              state_nxt = S_TAIL;
            end
          end
        end
      end
      S_SEMI: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = anee_pkg::SEL_SEMI;
          second_nxt = 1'b1;
          state_nxt  = S_LOAD;
        end
      end
      S_TAIL: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = (sts.kind == anee_pkg::KIND_CUR) ? anee_pkg::SEL_H : anee_pkg::SEL_M;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TWO: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = anee_pkg::SEL_TWO;
          state_nxt = S_JAY;
        end
      end
      S_JAY: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = anee_pkg::SEL_J;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/ascii_number_and_escape_emitter_unit.sv =====
// Top level of the ASCII number and escape-sequence emitter.
// Usage:
//   Input channel in_valid/in_ready/in_data carries one command item: kind,
//   value, row, column, color_code. Kind 0 prints value in decimal, kind 1 in
//   upper-case hex, kind 2 emits ESC [ row ; column H, kind 3 emits
//   ESC [ color_code m, kind 4 emits ESC [ 2 J; kinds 5 to 7 emit nothing.
//   Output channel out_valid/out_ready/out_data carries one character item
//   per cycle at most, with last set on the final byte of each run.
// Sequence:
//   One command at a time. A decimal number passes through the converter as
//   load, eight four-bit double-dabble steps and digit count, a hex number as
//   load and digit count; then each digit goes out as one byte, as does each
//   fixed character. The next command is accepted the cycle after the last
//   byte is loaded into the output register.
// Reset: rst_n low at a clock edge empties the output register and returns
//   the controller to idle; no clearing pass is needed.
// Stall: while out_ready is low the output register holds its item and the
//   controller waits; no byte is lost or repeated.
`default_nettype none

module ascii_number_and_escape_emitter_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire anee_pkg::anee_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output anee_pkg::anee_out_t      out_data
);

  anee_pkg::anee_cmd_t cmd;
  anee_pkg::anee_sts_t sts;

  anee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  anee_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/anee_check.sv =====
// Port-level checker for the emitter, bound to the top level.
`default_nettype none

module anee_check (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire anee_pkg::anee_out_t out_data
);

  // Reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  // An accepted command blocks the next one
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command accepted back to back");

  // The last byte of a run is a digit or a closing character
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |->
      (out_data.out_byte >= anee_pkg::CH_ZERO && out_data.out_byte <= 8'h39) ||
      (out_data.out_byte >= anee_pkg::CH_A && out_data.out_byte <= 8'h46) ||
      out_data.out_byte == anee_pkg::CH_H || out_data.out_byte == anee_pkg::CH_M ||
      out_data.out_byte == anee_pkg::CH_J)
    else $error("bad final byte of run");

endmodule

bind ascii_number_and_escape_emitter_unit anee_check u_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/ascii_number_and_escape_emitter_unit_tb.sv =====
// Self-checking testbench for the ASCII number and escape-sequence emitter.
module ascii_number_and_escape_emitter_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 1000;
  localparam int SETTLE_TIME  = 40;
  localparam int RANDOM_ITEMS = 270;
  localparam logic [2:0] KIND_SPARE = 3'd5;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  anee_pkg::anee_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  anee_pkg::anee_out_t out_data;

  // Characters still owed by the block, oldest first
  anee_pkg::anee_out_t pending_chars[$];
  logic [7:0]          run_buf[$];

  int errors;
  int chars_checked;
  int idle_cycles;
  int kind_count[8];

  // Sender burst shaping
  int burst_left;
  int gap_max;
  bit gapless;

  // Receiver stall pattern
  int rx_mode;
  int rx_count;
  int rx_run;

  ascii_number_and_escape_emitter_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Append the digits of v in the given base, most significant first
  function automatic void add_number(input logic [31:0] v, input logic [31:0] base);
    logic [7:0]  digs[$];
    logic [31:0] d;
    if (v == 32'd0) begin
      run_buf.push_back(anee_pkg::CH_ZERO);
    end
    while (v != 32'd0) begin
      d = v % base;
      if (d < 32'd10) begin
        digs.push_front(anee_pkg::CH_ZERO + d[7:0]);
      end else begin
        digs.push_front(anee_pkg::CH_A + d[7:0] - 8'd10);
      end
      v = v / base;
    end
    foreach (digs[i]) begin
      run_buf.push_back(digs[i]);
    end
  endfunction

  // Work out the run of characters for one command and queue it
  function automatic void format_command(input anee_pkg::anee_in_t c);
    anee_pkg::anee_out_t ch;
    run_buf.delete();
    case (c.kind)
      anee_pkg::KIND_DEC: add_number(c.value, 32'd10);
      anee_pkg::KIND_HEX: add_number(c.value, 32'd16);
      anee_pkg::KIND_CUR: begin
        run_buf.push_back(anee_pkg::CH_ESC);
        run_buf.push_back(anee_pkg::CH_LBRK);
        add_number({24'd0, c.row}, 32'd10);
        run_buf.push_back(anee_pkg::CH_SEMI);
        add_number({24'd0, c.column}, 32'd10);
        run_buf.push_back(anee_pkg::CH_H);
      end
      anee_pkg::KIND_COL: begin
        run_buf.push_back(anee_pkg::CH_ESC);
        run_buf.push_back(anee_pkg::CH_LBRK);
        add_number({24'd0, c.color_code}, 32'd10);
        run_buf.push_back(anee_pkg::CH_M);
      end
      anee_pkg::KIND_CLR: begin
        run_buf.push_back(anee_pkg::CH_ESC);
        run_buf.push_back(anee_pkg::CH_LBRK);
        run_buf.push_back(anee_pkg::CH_TWO);
        run_buf.push_back(anee_pkg::CH_J);
      end
      default: begin
      end
    endcase
    foreach (run_buf[i]) begin
      ch.out_byte = run_buf[i];
      ch.last     = (i == run_buf.size() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  // Predict on every accepted command, check every accepted character
  always @(posedge clk) begin : check_chars
    anee_pkg::anee_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        format_command(in_data);
      end
      if (out_valid && out_ready) begin
        chars_checked++;
        if (pending_chars.size() == 0) begin
          $error("unexpected character item: out_byte %0h last %0b",
                 out_data.out_byte, out_data.last);
          errors++;
        end else begin
          want = pending_chars.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_data.out_byte);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            errors++;
          end
        end
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: switch between full speed, scattered stalls and long stall runs
  always @(negedge clk) begin
    if (rx_count == 0) begin
      rx_mode  <= $urandom_range(0, 2);
      rx_count <= $urandom_range(20, 120);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_run == 0) begin
          out_ready <= !out_ready;
          rx_run    <= $urandom_range(1, 12);
        end else begin
          rx_run <= rx_run - 1;
        end
      end
    endcase
  end

  // Send one command, with a random gap at the start of each burst unless gapless is set
  task automatic issue_command(input anee_pkg::anee_in_t c);
    int          gap;
    logic [63:0] junk;
    if (burst_left == 0) begin
      gap = gapless ? 0 : $urandom_range(1, gap_max);
      repeat (gap) begin
        @(negedge clk);
        junk     = {$urandom, $urandom};
        in_valid <= 1'b0;
        in_data  <= junk[$bits(anee_pkg::anee_in_t)-1:0];
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= c;
    kind_count[c.kind]++;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  // Hold the sender off until every owed character has come out
  task automatic drain_outputs();
    do begin
      @(negedge clk);
      in_valid <= 1'b0;
    end while (pending_chars.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic anee_pkg::anee_in_t make_command(input logic [2:0] k,
                                                      input logic [31:0] v,
                                                      input logic [7:0] r,
                                                      input logic [7:0] col,
                                                      input logic [7:0] clr);
    anee_pkg::anee_in_t c;
    c.kind       = k;
    c.value      = v;
    c.row        = r;
    c.column     = col;
    c.color_code = clr;
    return c;
  endfunction

  // Number of one, two or three digits, or any byte
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 9));
      1:       return 8'($urandom_range(10, 99));
      2:       return 8'($urandom_range(100, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom >> $urandom_range(0, 31);
      2:       return $urandom_range(0, 99);
      default: return (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
    endcase
  endfunction

  // Decimal: zero, single digits, digit-count boundaries and the maximum
  task automatic test_decimal_edges();
    logic [31:0] vals[7] = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd999999999,
                             32'd1000000000, 32'hFFFFFFFF};
    foreach (vals[i]) begin
      issue_command(make_command(anee_pkg::KIND_DEC, vals[i], 8'($urandom),
                                 8'($urandom), 8'($urandom)));
    end
  endtask

  // Hex: zero, nibble boundaries, top bit alone and all ones
  task automatic test_hex_edges();
    logic [31:0] vals[5] = '{32'h0, 32'hF, 32'h10, 32'h80000000, 32'hFFFFFFFF};
    foreach (vals[i]) begin
      issue_command(make_command(anee_pkg::KIND_HEX, vals[i], 8'($urandom),
                                 8'($urandom), 8'($urandom)));
    end
  endtask

  // Cursor position at both extremes and across a digit boundary
  task automatic test_cursor();
    issue_command(make_command(anee_pkg::KIND_CUR, $urandom, 8'd0, 8'd0, 8'($urandom)));
    issue_command(make_command(anee_pkg::KIND_CUR, $urandom, 8'd255, 8'd255,
                               8'($urandom)));
    issue_command(make_command(anee_pkg::KIND_CUR, $urandom, 8'd9, 8'd10, 8'($urandom)));
  endtask

  task automatic test_color();
    issue_command(make_command(anee_pkg::KIND_COL, $urandom, 8'($urandom), 8'($urandom),
                               8'd0));
    issue_command(make_command(anee_pkg::KIND_COL, $urandom, 8'($urandom), 8'($urandom),
                               8'd255));
    issue_command(make_command(anee_pkg::KIND_COL, $urandom, 8'($urandom), 8'($urandom),
                               8'd37));
  endtask

  // Clear screen ignores every other field
  task automatic test_clear();
    issue_command(make_command(anee_pkg::KIND_CLR, $urandom, 8'($urandom), 8'($urandom),
                               8'($urandom)));
  endtask

  // Spare kinds must emit nothing; a clear screen behind each one proves it
  task automatic test_spare_kinds();
    for (int k = KIND_SPARE; k <= 7; k++) begin
      issue_command(make_command(3'(k), $urandom, 8'($urandom), 8'($urandom),
                                 8'($urandom)));
    end
    test_clear();
  endtask

  // Random mix, mostly real commands with some spare kinds as noise
  task automatic test_random_commands();
    int                 sent;
    int                 pick;
    anee_pkg::anee_in_t c;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick >= 18) begin
        c.kind = 3'($urandom_range(KIND_SPARE, 7));
      end else begin
        c.kind = 3'(pick % 5);
      end
      c.value      = pick_value();
      c.row        = pick_byte();
      c.column     = pick_byte();
      c.color_code = pick_byte();
      issue_command(c);
      if (c.kind < KIND_SPARE) begin
        sent++;
        if (sent % 75 == 0) begin
          drain_outputs();
        end
        if (sent % 60 == 0) begin
          gapless = !gapless;
          gap_max = $urandom_range(2, 25);
        end
      end
    end
  endtask

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    errors     = 0;
    idle_cycles = 0;
    chars_checked = 0;
    burst_left = 0;
    gap_max    = 6;
    gapless    = 1'b0;
    rx_mode    = 0;
    rx_count   = 0;
    rx_run     = 0;
    foreach (kind_count[i]) kind_count[i] = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_decimal_edges();
    test_hex_edges();
    test_cursor();
    test_color();
    test_clear();
    test_spare_kinds();
    drain_outputs();
    test_random_commands();

    // Stop sending, let the last run finish, then allow a quiet tail
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_TIME) @(posedge clk);

    $display("covered: %0d decimal, %0d hex, %0d cursor, %0d color, %0d clear commands",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
    $display("covered: %0d spare-kind commands, %0d characters checked, %0d mismatches",
             kind_count[5] + kind_count[6] + kind_count[7], chars_checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
